// File: hw/rtl/gcpi_pkg.sv
// ----------------------------------------------------------------------------
// gcpi_pkg
// shared types and constants for the gravity compensated peak impact unit
// ----------------------------------------------------------------------------
package gcpi_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_SAMPLE    = 2'd0;
  localparam logic [1:0] OP_CLEAR     = 2'd1;
  localparam logic [1:0] OP_CALIBRATE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_TOL = 2'd1;

  localparam int CFG_W = 15;
  localparam int MAG_W = 17;

  localparam logic [CFG_W-1:0] ONE_G_RESET    = 15'd16384;
  localparam logic [CFG_W-1:0] REST_TOL_RESET = 15'd5734;
  localparam int               GRAVITY_Z_RESET = -16384;

  // load / step control for the serial arithmetic units
  typedef struct packed {
    logic load;
    logic step;
  } seq_ctl_t;

endpackage

// File: hw/rtl/gravity_compensated_peak_impact_unit.sv
// ----------------------------------------------------------------------------
// gravity_compensated_peak_impact_unit
// accelerometer gravity removal with integer-root impact and peak tracking
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_operation, in_accel_x/y/z
//  out_     output     out_valid/out_stall  out_impact_magnitude,
//                                           out_peak_magnitude, out_new_peak,
//                                           out_at_rest
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  a sample transaction runs GW steps of the bit-serial squarers (GW being
//  the larger of SAMPLE_BITS and 15), a sum and root load, GW+1 steps of
//  the bit-serial roots, plus accept and write-back; clear, calibrate and
//  the unused code go from accept straight to write-back
//  one transaction is in flight at a time; the result register lets the next
//  transaction enter while the previous result still waits on out_stall
//  rst_n is synchronous, active low; config and state take their reset values, handshakes are cleared
// ----------------------------------------------------------------------------
module gravity_compensated_peak_impact_unit
  import gcpi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [MAG_W-1:0]              out_impact_magnitude,
  output logic [MAG_W-1:0]              out_peak_magnitude,
  output logic                          out_new_peak,
  output logic                          out_at_rest,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  // gravity must hold the -1 g reset value, so it never drops below 15 bits
  localparam int GW    = (SAMPLE_BITS > 15) ? SAMPLE_BITS : 15;
  localparam int RW    = GW + 1;                 // root width
  localparam int CNT_W = $clog2(2 * GW + 2);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CALC  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // configuration
  logic [CFG_W-1:0] one_g_r, rest_tol_r;

  // architectural state
  logic signed [GW-1:0]          grav_x_r, grav_y_r, grav_z_r;
  logic signed [SAMPLE_BITS-1:0] last_x_r, last_y_r, last_z_r;
  logic [RW-1:0]                 peak_r;

  // captured transaction
  logic [1:0]                    op_r;
  logic signed [SAMPLE_BITS-1:0] x_r, y_r, z_r;

  // result register
  logic             out_valid_r;
  logic [MAG_W-1:0] out_impact_r, out_peak_r;
  logic             out_new_peak_r, out_at_rest_r;

  logic accept, out_free, retire;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign retire    = (state_r == ST_WRITE) && out_free;

  // ---------------------------------------------------------------------------
  // operand magnitudes, formed at accept straight from the ports
  // raw magnitude for the rest test, gravity-free magnitude against the old
  // gravity; if the sample turns out at rest the impact is forced to zero
  // ---------------------------------------------------------------------------
  logic signed [GW:0] ax, ay, az, dx, dy, dz;
  logic [GW-1:0]      ax_mag, ay_mag, az_mag, dx_mag, dy_mag, dz_mag;

  function automatic logic [GW-1:0] abs_mag(input logic signed [GW:0] v);
    logic signed [GW:0] n;
    n = -v;
    return v[GW] ? n[GW-1:0] : v[GW-1:0];
  endfunction

  always_comb begin
    ax = (GW+1)'(in_accel_x);
    ay = (GW+1)'(in_accel_y);
    az = (GW+1)'(in_accel_z);
    dx = ax - (GW+1)'(grav_x_r);
    dy = ay - (GW+1)'(grav_y_r);
    dz = az - (GW+1)'(grav_z_r);
    ax_mag = abs_mag(ax);
    ay_mag = abs_mag(ay);
    az_mag = abs_mag(az);
    dx_mag = abs_mag(dx);
    dy_mag = abs_mag(dy);
    dz_mag = abs_mag(dz);
  end

  // ---------------------------------------------------------------------------
  // sequencing: squares on counts 0..GW-1, sum and root load on GW,
  // root steps on GW+1..2*GW+1
  // ---------------------------------------------------------------------------
  seq_ctl_t sq_ctl, rt_ctl;

  always_comb begin
    sq_ctl.load = accept;
    sq_ctl.step = (state_r == ST_CALC) && (cnt_r < CNT_W'(GW));
    rt_ctl.load = (state_r == ST_CALC) && (cnt_r == CNT_W'(GW));
    rt_ctl.step = (state_r == ST_CALC) && (cnt_r > CNT_W'(GW));
  end

  logic [2*GW-1:0] sq_ax, sq_ay, sq_az, sq_dx, sq_dy, sq_dz;
  logic [2*RW-1:0] raw_sum, imp_sum;
  logic [RW-1:0]   raw_root, imp_root;

  gcpi_sqr #(.N(GW)) u_sq_ax (.clk(clk), .ctl(sq_ctl), .a(ax_mag), .sq(sq_ax));
  gcpi_sqr #(.N(GW)) u_sq_ay (.clk(clk), .ctl(sq_ctl), .a(ay_mag), .sq(sq_ay));
  gcpi_sqr #(.N(GW)) u_sq_az (.clk(clk), .ctl(sq_ctl), .a(az_mag), .sq(sq_az));
  gcpi_sqr #(.N(GW)) u_sq_dx (.clk(clk), .ctl(sq_ctl), .a(dx_mag), .sq(sq_dx));
  gcpi_sqr #(.N(GW)) u_sq_dy (.clk(clk), .ctl(sq_ctl), .a(dy_mag), .sq(sq_dy));
  gcpi_sqr #(.N(GW)) u_sq_dz (.clk(clk), .ctl(sq_ctl), .a(dz_mag), .sq(sq_dz));

  // three squares below 2^(2*GW) each sum below 2^(2*GW+2)
  assign raw_sum = (2*RW)'(sq_ax) + (2*RW)'(sq_ay) + (2*RW)'(sq_az);
  assign imp_sum = (2*RW)'(sq_dx) + (2*RW)'(sq_dy) + (2*RW)'(sq_dz);

  gcpi_isqrt #(.R(RW)) u_rt_raw (.clk(clk), .ctl(rt_ctl), .rad(raw_sum), .root(raw_root));
  gcpi_isqrt #(.R(RW)) u_rt_imp (.clk(clk), .ctl(rt_ctl), .rad(imp_sum), .root(imp_root));

  // ---------------------------------------------------------------------------
  // write-back decisions
  // ---------------------------------------------------------------------------
  logic [RW-1:0] g_ext, rest_dist;
  logic          is_sample, rest, new_peak;
  logic [RW-1:0] impact, peak_nxt;

  always_comb begin
    g_ext     = RW'(one_g_r);
    rest_dist = (raw_root >= g_ext) ? (raw_root - g_ext) : (g_ext - raw_root);
    is_sample = (op_r == OP_SAMPLE);
    rest      = is_sample && (rest_dist < RW'(rest_tol_r));
    impact    = (is_sample && !rest) ? imp_root : '0;
    new_peak  = is_sample && (impact > peak_r);
    case (op_r)
      OP_SAMPLE:    peak_nxt = new_peak ? impact : peak_r;
      OP_CLEAR,
      OP_CALIBRATE: peak_nxt = '0;
      default:      peak_nxt = peak_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control state machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = (in_operation == OP_SAMPLE) ? ST_CALC : ST_WRITE;
        end
      end
      ST_CALC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(2 * GW + 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      one_g_r     <= ONE_G_RESET;
      rest_tol_r  <= REST_TOL_RESET;
      grav_x_r    <= '0;
      grav_y_r    <= '0;
      grav_z_r    <= GW'(GRAVITY_Z_RESET);
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      peak_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;

      // config register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ONE_G:    one_g_r    <= cfg_data;
          REG_REST_TOL: rest_tol_r <= cfg_data;
          default: ;
        endcase
      end

      // result handshake
      if (retire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // architectural state update at retire
      if (retire) begin
        peak_r <= peak_nxt;
        case (op_r)
          OP_SAMPLE: begin
            last_x_r <= x_r;
            last_y_r <= y_r;
            last_z_r <= z_r;
            if (rest) begin
              grav_x_r <= GW'(x_r);
              grav_y_r <= GW'(y_r);
              grav_z_r <= GW'(z_r);
            end
          end
          OP_CALIBRATE: begin
            grav_x_r <= GW'(last_x_r);
            grav_y_r <= GW'(last_y_r);
            grav_z_r <= GW'(last_z_r);
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      x_r  <= in_accel_x;
      y_r  <= in_accel_y;
      z_r  <= in_accel_z;
    end
    if (retire) begin
      out_impact_r   <= MAG_W'(impact);
      out_peak_r     <= MAG_W'(peak_nxt);
      out_new_peak_r <= new_peak;
      out_at_rest_r  <= rest;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_impact_magnitude = out_impact_r;
  assign out_peak_magnitude   = out_peak_r;
  assign out_new_peak         = out_new_peak_r;
  assign out_at_rest          = out_at_rest_r;

`ifndef SYNTH
  // a raised peak is the impact of the same transaction
  a_new_peak_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_peak |-> out_impact_magnitude == out_peak_magnitude)
    else $error("new peak differs from impact");

  // a sample taken as gravity has no gravity-free acceleration left
  a_rest_zero_impact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_rest |-> out_impact_magnitude == '0)
    else $error("at-rest sample with nonzero impact");

  // a retiring transaction always lands in the result register
  a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> out_valid && state_r == ST_IDLE)
    else $error("retired result not presented");

  // roots are only stepped after the squares have finished
  a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
    rt_ctl.load |-> $past(sq_ctl.step) && !sq_ctl.step)
    else $error("root loaded before squares done");
`endif

endmodule

// File: hw/rtl/gcpi_sqr.sv
// ----------------------------------------------------------------------------
// gcpi_sqr
// bit-serial squarer, one multiplier bit per step
// ----------------------------------------------------------------------------
module gcpi_sqr
  import gcpi_pkg::*;
#(
  parameter int N = 16
) (
  input  logic           clk,
  input  seq_ctl_t       ctl,
  input  logic [N-1:0]   a,
  output logic [2*N-1:0] sq
);

  logic [2*N-1:0] mcand_r;
  logic [N-1:0]   mplier_r;
  logic [2*N-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand_r  <= {{N{1'b0}}, a};
      mplier_r <= a;
      acc_r    <= '0;
    end else if (ctl.step) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[2*N-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[N-1:1]};
    end
  end

  assign sq = acc_r;

endmodule

// File: hw/rtl/gcpi_isqrt.sv
// ----------------------------------------------------------------------------
// gcpi_isqrt
// restoring integer square root, one root bit per step
// ----------------------------------------------------------------------------
module gcpi_isqrt
  import gcpi_pkg::*;
#(
  parameter int R = 17
) (
  input  logic           clk,
  input  seq_ctl_t       ctl,
  input  logic [2*R-1:0] rad,
  output logic [R-1:0]   root
);

  logic [2*R-1:0] rad_r;
  logic [R+1:0]   rem_r;
  logic [R-1:0]   root_r;
  logic [R+3:0]   rem_t;
  logic [R+3:0]   trial;
  logic [R+3:0]   diff;
  logic           ge;

  always_comb begin
    rem_t = {rem_r, rad_r[2*R-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    diff  = rem_t - trial;
    ge    = (rem_t >= trial);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctl.step) begin
      rad_r  <= {rad_r[2*R-3:0], 2'b00};
      rem_r  <= ge ? diff[R+1:0] : rem_t[R+1:0];
      root_r <= {root_r[R-2:0], ge};
    end
  end

  assign root = root_r;

endmodule
